// File: design/flash_eeprom_emulation_defines.svh
// ----------------------------------------------------------------------------
// flash eeprom emulation assertion macros
// shared concurrent assertion forms, clocked on clk and gated by rst_n
// ----------------------------------------------------------------------------
`ifndef FLASH_EEPROM_EMULATION_DEFINES_SVH
`define FLASH_EEPROM_EMULATION_DEFINES_SVH

// consequent holds in the same cycle
`define FEE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the following cycle
`define FEE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fee_pkg.sv
// ----------------------------------------------------------------------------
// fee_pkg
// sizes, codes and item types shared by the flash eeprom emulation modules
// ----------------------------------------------------------------------------
package fee_pkg;

    localparam int PAGE_SLOTS = 4096;
    localparam int VAR_COUNT  = 2048;

    localparam int MEM_DEPTH = 2 * PAGE_SLOTS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int SLOT_W    = $clog2(PAGE_SLOTS);
    localparam int VA_W      = $clog2(VAR_COUNT + 1);
    localparam int WORD_W    = 32;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_NOVALID  = 2'd2;
    localparam logic [1:0] STAT_RANGE    = 2'd3;

    localparam logic [15:0] HDR_ERASED  = 16'hFFFF;
    localparam logic [15:0] HDR_RECEIVE = 16'hEEEE;
    localparam logic [15:0] HDR_VALID   = 16'h0000;

    localparam logic [7:0] DATA_ABSENT = 8'hFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [7:0]  data;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
    } res_t;

    // flat memory index of a page slot
    function automatic logic [MEM_AW-1:0] mem_index(logic page, logic [SLOT_W-1:0] slot);
        logic [MEM_AW-1:0] base;
        base = page ? MEM_AW'(PAGE_SLOTS) : '0;
        return base + MEM_AW'(slot);
    endfunction

endpackage

// File: design/fee_ram.sv
// ----------------------------------------------------------------------------
// fee_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/fee_ctrl.sv
// ----------------------------------------------------------------------------
// fee_ctrl
// sequencer that scans, appends, copies and erases records in the page ram
// ----------------------------------------------------------------------------
`include "flash_eeprom_emulation_defines.svh"

module fee_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  fee_pkg::cmd_t cmd,
    output logic          ready,
    output logic          res_valid,
    output fee_pkg::res_t res,
    input  logic          res_take
);
    import fee_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_LKSTART  = 4'd1;
    localparam logic [3:0] ST_LOOK     = 4'd2;
    localparam logic [3:0] ST_APSTART  = 4'd3;
    localparam logic [3:0] ST_APPEND   = 4'd4;
    localparam logic [3:0] ST_ERASE    = 4'd5;
    localparam logic [3:0] ST_REPAIR   = 4'd6;
    localparam logic [3:0] ST_SKIP_RD  = 4'd7;
    localparam logic [3:0] ST_SKIP_GET = 4'd8;
    localparam logic [3:0] ST_CP_NEXT  = 4'd9;
    localparam logic [3:0] ST_FIN      = 4'd10;
    localparam logic [3:0] ST_DONE     = 4'd11;

    localparam logic LC_READ = 1'b0;
    localparam logic LC_COPY = 1'b1;

    localparam logic [1:0] AC_WRITE = 2'd0;
    localparam logic [1:0] AC_XFER  = 2'd1;
    localparam logic [1:0] AC_COPY  = 2'd2;

    localparam logic [1:0] EC_DONE = 2'd0;
    localparam logic [1:0] EC_FIN  = 2'd1;
    localparam logic [1:0] EC_CLR  = 2'd2;
    localparam logic [1:0] EC_IDLE = 2'd3;

    logic [3:0]        state_reg, state_next;
    logic              page_reg, page_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic [VA_W-1:0]   va_reg, va_next;
    logic              tgt_reg, tgt_next;
    logic              lctx_reg, lctx_next;
    logic [1:0]        actx_reg, actx_next;
    logic [1:0]        ectx_reg, ectx_next;
    logic [1:0][15:0]  hdr_reg, hdr_next;
    logic [15:0]       key_reg, key_next;
    logic [15:0]       val_reg, val_next;
    logic [15:0]       skip_reg, skip_next;
    res_t              res_reg, res_next;

    logic              ram_we;
    logic [MEM_AW-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [MEM_AW-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic rd_ok, rd_page, wr_ok, wr_page, key_hit;

    fee_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // page selection from the cached headers
    always_comb
    begin
        rd_ok   = (hdr_reg[0] == HDR_VALID) || (hdr_reg[1] == HDR_VALID);
        rd_page = (hdr_reg[0] != HDR_VALID);
        wr_ok   = rd_ok;
        if (hdr_reg[1] == HDR_VALID)
        begin
            wr_page = (hdr_reg[0] != HDR_RECEIVE);
        end
        else
        begin
            wr_page = (hdr_reg[1] == HDR_RECEIVE);
        end
    end

    assign key_hit = (ram_rdata[31:16] == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        page_next      = page_reg;
        slot_next      = slot_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        va_next        = va_reg;
        tgt_next       = tgt_reg;
        lctx_next      = lctx_reg;
        actx_next      = actx_reg;
        ectx_next      = ectx_reg;
        hdr_next       = hdr_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        skip_next      = skip_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = mem_index(page_reg, slot_reg);
        ram_wdata      = '1;
        ram_raddr      = mem_index(page_reg, slot_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    key_next = cmd.address;
                    val_next = {8'h00, cmd.data};
                    res_next = '{read_data: DATA_ABSENT, status: STAT_RANGE};
                    unique case (cmd.opcode)
                        OP_READ:
                        begin
                            lctx_next  = LC_READ;
                            state_next = (cmd.address < 16'(VAR_COUNT)) ? ST_LKSTART
                                                                        : ST_DONE;
                        end
                        OP_WRITE:
                        begin
                            actx_next  = AC_WRITE;
                            state_next = (cmd.address < 16'(VAR_COUNT)) ? ST_APSTART
                                                                        : ST_DONE;
                        end
                        OP_INIT:
                        begin
                            state_next = ST_REPAIR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_LKSTART:
            begin
                if (rd_ok)
                begin
                    page_next  = rd_page;
                    slot_next  = SLOT_W'(PAGE_SLOTS - 1);
                    pend_next  = 1'b0;
                    state_next = ST_LOOK;
                end
                else if (lctx_reg == LC_READ)
                begin
                    res_next   = '{read_data: DATA_ABSENT, status: STAT_NOVALID};
                    state_next = ST_DONE;
                end
                else
                begin
                    va_next    = va_reg + 1'b1;
                    state_next = ST_CP_NEXT;
                end
            end

            // downward scan, newest record first
            ST_LOOK:
            begin
                pend_next      = 1'b1;
                pend_slot_next = slot_reg;
                slot_next      = slot_reg - 1'b1;
                if (pend_reg && key_hit)
                begin
                    if (lctx_reg == LC_READ)
                    begin
                        res_next   = '{read_data: ram_rdata[7:0], status: STAT_OK};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        val_next   = ram_rdata[15:0];
                        actx_next  = AC_COPY;
                        state_next = ST_APSTART;
                    end
                end
                else if (pend_reg && (pend_slot_reg == SLOT_W'(1)))
                begin
                    if (lctx_reg == LC_READ)
                    begin
                        res_next   = '{read_data: DATA_ABSENT, status: STAT_NOTFOUND};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        va_next    = va_reg + 1'b1;
                        state_next = ST_CP_NEXT;
                    end
                end
            end

            ST_APSTART:
            begin
                if (wr_ok)
                begin
                    page_next  = wr_page;
                    slot_next  = SLOT_W'(1);
                    pend_next  = 1'b0;
                    state_next = ST_APPEND;
                end
                else
                begin
                    res_next   = '{read_data: DATA_ABSENT, status: STAT_NOVALID};
                    state_next = ST_DONE;
                end
            end

            // upward scan for the first erased slot
            ST_APPEND:
            begin
                pend_next      = 1'b1;
                pend_slot_next = slot_reg;
                slot_next      = slot_reg + 1'b1;
                if (pend_reg && (ram_rdata == '1))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = mem_index(page_reg, pend_slot_reg);
                    ram_wdata = {key_reg, val_reg};
                    unique case (actx_reg)
                        AC_WRITE:
                        begin
                            res_next   = '{read_data: DATA_ABSENT, status: STAT_OK};
                            state_next = ST_DONE;
                        end
                        AC_XFER:
                        begin
                            skip_next  = key_reg;
                            va_next    = '0;
                            state_next = ST_CP_NEXT;
                        end
                        default:
                        begin
                            va_next    = va_reg + 1'b1;
                            state_next = ST_CP_NEXT;
                        end
                    endcase
                end
                else if (pend_reg && (pend_slot_reg == SLOT_W'(PAGE_SLOTS - 1)))
                begin
                    if ((actx_reg == AC_WRITE) && rd_ok)
                    begin
                        // page full: start a transfer into the other page
                        hdr_next[~rd_page] = hdr_reg[~rd_page] & HDR_RECEIVE;
                        tgt_next           = ~rd_page;
                        actx_next          = AC_XFER;
                        state_next         = ST_APSTART;
                    end
                    else
                    begin
                        res_next   = '{read_data: DATA_ABSENT, status: STAT_NOVALID};
                        state_next = ST_DONE;
                    end
                end
            end

            ST_CP_NEXT:
            begin
                if (va_reg == VA_W'(VAR_COUNT))
                begin
                    state_next = ST_FIN;
                end
                else if (16'(va_reg) == skip_reg)
                begin
                    va_next = va_reg + 1'b1;
                end
                else
                begin
                    key_next   = 16'(va_reg);
                    lctx_next  = LC_COPY;
                    state_next = ST_LKSTART;
                end
            end

            // mark the target page valid and erase the other one
            ST_FIN:
            begin
                hdr_next[tgt_reg]  = HDR_VALID;
                hdr_next[~tgt_reg] = HDR_ERASED;
                page_next          = ~tgt_reg;
                slot_next          = '0;
                ectx_next          = EC_DONE;
                state_next         = ST_ERASE;
            end

            ST_ERASE:
            begin
                ram_we    = 1'b1;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SLOT_W'(PAGE_SLOTS - 1))
                begin
                    unique case (ectx_reg)
                        EC_DONE:
                        begin
                            res_next   = '{read_data: DATA_ABSENT, status: STAT_OK};
                            state_next = ST_DONE;
                        end
                        EC_FIN:
                        begin
                            state_next = ST_FIN;
                        end
                        EC_CLR:
                        begin
                            page_next = 1'b1;
                            slot_next = '0;
                            ectx_next = EC_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_REPAIR:
            begin
                res_next = '{read_data: DATA_ABSENT, status: STAT_OK};
                // format unless a case below decides otherwise
                page_next   = 1'b0;
                slot_next   = '0;
                hdr_next[0] = HDR_ERASED;
                ectx_next   = EC_FIN;
                tgt_next    = 1'b0;
                state_next  = ST_ERASE;
                unique case (hdr_reg[0])
                    HDR_ERASED:
                    begin
                        if (hdr_reg[1] == HDR_VALID)
                        begin
                            ectx_next = EC_DONE;
                        end
                        else if (hdr_reg[1] == HDR_RECEIVE)
                        begin
                            hdr_next   = hdr_reg;
                            tgt_next   = 1'b1;
                            state_next = ST_FIN;
                        end
                    end
                    HDR_RECEIVE:
                    begin
                        if (hdr_reg[1] == HDR_VALID)
                        begin
                            hdr_next   = hdr_reg;
                            state_next = ST_SKIP_RD;
                        end
                        else if (hdr_reg[1] == HDR_ERASED)
                        begin
                            hdr_next   = hdr_reg;
                            state_next = ST_FIN;
                        end
                    end
                    HDR_VALID:
                    begin
                        if (hdr_reg[1] == HDR_ERASED)
                        begin
                            hdr_next  = hdr_reg;
                            page_next = 1'b1;
                            ectx_next = EC_DONE;
                        end
                        else if (hdr_reg[1] != HDR_VALID)
                        begin
                            // odd header on page 1 counts as receiving
                            hdr_next   = hdr_reg;
                            page_next  = 1'b1;
                            tgt_next   = 1'b1;
                            state_next = ST_SKIP_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_ERASE;
                    end
                endcase
            end

            // variable already placed in slot 1 of the receiving page
            ST_SKIP_RD:
            begin
                ram_raddr  = mem_index(page_reg, SLOT_W'(1));
                state_next = ST_SKIP_GET;
            end

            ST_SKIP_GET:
            begin
                skip_next  = ram_rdata[31:16];
                va_next    = '0;
                state_next = ST_CP_NEXT;
            end

            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset sweeps both pages to the erased state
            state_reg     <= ST_ERASE;
            page_reg      <= 1'b0;
            slot_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_slot_reg <= '0;
            va_reg        <= '0;
            tgt_reg       <= 1'b0;
            lctx_reg      <= LC_READ;
            actx_reg      <= AC_WRITE;
            ectx_reg      <= EC_CLR;
            hdr_reg       <= {HDR_ERASED, HDR_ERASED};
        end
        else
        begin
            state_reg     <= state_next;
            page_reg      <= page_next;
            slot_reg      <= slot_next;
            pend_reg      <= pend_next;
            pend_slot_reg <= pend_slot_next;
            va_reg        <= va_next;
            tgt_reg       <= tgt_next;
            lctx_reg      <= lctx_next;
            actx_reg      <= actx_next;
            ectx_reg      <= ectx_next;
            hdr_reg       <= hdr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        val_reg  <= val_next;
        skip_reg <= skip_next;
        res_reg  <= res_next;
    end

    assign ready     = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    `FEE_ASSERT_NOW(a_idle_no_write, state_reg == ST_IDLE, !ram_we, "flash written while idle")
    `FEE_ASSERT_NOW(a_absent_reads_ff, res_valid && (res.status == STAT_NOTFOUND), res.read_data == DATA_ABSENT, "missing variable returned data")
    `FEE_ASSERT_NEXT(a_take_frees, res_valid && res_take, ready, "sequencer not free after result taken")
    `FEE_ASSERT_NOW(a_record_key, ram_we && (state_reg == ST_APPEND), ram_wdata[31:16] < 16'(VAR_COUNT), "record written with bad address")

endmodule

// File: design/flash_eeprom_emulation.sv
// ----------------------------------------------------------------------------
// flash_eeprom_emulation
// byte eeprom kept as address/data records in two flash pages
// ----------------------------------------------------------------------------
// One item in, one result item out. A read scans the valid page from its
// last slot down, through the single read port of the page ram. A write
// scans upward for the first erased slot. When the page is full, the write
// turns into a page transfer: a lookup for every other variable and an
// append for each one found, followed by an erase of the old page.
// Init repairs the page headers and can run the same transfer or erases.
// After reset the block sweeps both pages to the erased state and holds
// cmd_stall high until the sweep is done. A finished result sits in the
// output register, so the next item is taken while it waits for res_stall
// to drop.
module flash_eeprom_emulation (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    // result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  read_data,
    output logic [1:0]  status
);
    import fee_pkg::*;

    cmd_t cmd;
    res_t seq_res;
    logic seq_ready;
    logic seq_valid;
    logic take;

    // output stage registers
    logic       out_valid_reg, out_valid_next;
    logic [7:0] read_data_reg;
    logic [1:0] status_reg;

    assign cmd = '{opcode: opcode, address: address, data: data};

    // the sequencer takes an item only when it is idle
    assign cmd_stall = !seq_ready;

    fee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .ready     (seq_ready),
        .res_valid (seq_valid),
        .res       (seq_res),
        .res_take  (take)
    );

    // output stage can load when empty or when its item leaves this cycle
    assign take = !out_valid_reg || !res_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = seq_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, held while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (take && seq_valid)
        begin
            read_data_reg <= seq_res.read_data;
            status_reg    <= seq_res.status;
        end
    end

    assign res_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;

endmodule
